[rtl/core/script_character_tokenizer_macros.svh]
// assertion macros shared by the checker
`ifndef SCRIPT_CHARACTER_TOKENIZER_MACROS_SVH
`define SCRIPT_CHARACTER_TOKENIZER_MACROS_SVH

// same-cycle implication, clocked on clk_i, quiet while rst_ni is low
`define SCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sct check failed");

// next-cycle implication
`define SCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sct check failed");

`endif

[rtl/core/sct_pkg.sv]
`timescale 1ns / 1ps
package sct_pkg;

  // character codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  localparam int unsigned MaxRes = 4;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_COMMENT = 2'd3
  } lex_mode_e;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_BSLASH = 2'd1,
    ESC_QUOTE  = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       token_start;
    logic       token_end;
    logic       last_of_run;
  } out_item_t;

  // one token character before the run mark is known
  typedef struct packed {
    logic [7:0] ch;
    logic       tok_start;
    logic       tok_end;
  } tok_t;

  typedef struct packed {
    logic [7:0] la_char;
    logic       la_valid;
    lex_mode_e  mode;
    esc_e       esc;
    logic [7:0] held_op;
    logic       held_valid;
    logic       tok_open;
  } lex_state_t;

  // all results of one input transaction
  typedef struct packed {
    logic [2:0]           cnt;
    tok_t [MaxRes-1:0]    res;
  } bundle_t;

endpackage

[rtl/core/script_character_tokenizer.sv]
// the first result of a transaction is offered in the cycle after it is accepted
// one input transaction per cycle while each yields at most one result and the
//   output is not stalled; n results (0 to 4) hold the output register until sent
// the single result register sets the rate, one character per cycle unless stalled
// reset: rst_ni low clears lookahead, lexer mode, busy flag and index at once
`timescale 1ns / 1ps
module script_character_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sct_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sct_pkg::out_item_t  out_data_o
);

  // all the lexing for one byte happens between the state register in the
  // lexer and the result register in the drain stage
  sct_pkg::bundle_t  bundle;
  logic              in_accept;
  logic              drain_free;

  // the input is only held off while a run of results is still waiting;
  // when the last one of the run leaves, the next transaction goes straight in
  assign in_stall_o = !drain_free;
  assign in_accept  = in_valid_i && drain_free;

  sct_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .bundle_o (bundle)
  );

  // result register and serialiser, up to four token characters per transaction
  sct_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .bundle_i    (bundle),
    .free_o      (drain_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/sct_lexer.sv]
`timescale 1ns / 1ps
module sct_lexer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  sct_pkg::in_item_t   item_i,
  output sct_pkg::bundle_t    bundle_o
);

  // results of one character step, two at most
  typedef struct packed {
    sct_pkg::lex_state_t  st;
    logic [1:0]           cnt;
    sct_pkg::tok_t [1:0]  res;
  } take_t;

  function automatic logic is_space(logic [7:0] c);
    return c == sct_pkg::CH_SPACE || c == sct_pkg::CH_TAB || c == sct_pkg::CH_NL ||
           c == sct_pkg::CH_VT || c == sct_pkg::CH_FF || c == sct_pkg::CH_CR;
  endfunction

  function automatic logic is_mark(logic [7:0] c);
    return c == sct_pkg::CH_COMMA || c == sct_pkg::CH_SEMI || c == sct_pkg::CH_LPAR ||
           c == sct_pkg::CH_RPAR || c == sct_pkg::CH_LBRACE || c == sct_pkg::CH_RBRACE ||
           c == sct_pkg::CH_LBRACK || c == sct_pkg::CH_RBRACK || c == sct_pkg::CH_STAR ||
           c == sct_pkg::CH_SLASH || c == sct_pkg::CH_PLUS || c == sct_pkg::CH_MINUS ||
           c == sct_pkg::CH_EQ || c == sct_pkg::CH_BANG || c == sct_pkg::CH_GT ||
           c == sct_pkg::CH_LT || c == sct_pkg::CH_TILDE || c == sct_pkg::CH_AMP ||
           c == sct_pkg::CH_CARET || c == sct_pkg::CH_PIPE || c == sct_pkg::CH_PCT ||
           c == sct_pkg::CH_HASH;
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return is_space(c) || is_mark(c);
  endfunction

  function automatic logic can_lead(logic [7:0] c);
    return c == sct_pkg::CH_PLUS || c == sct_pkg::CH_MINUS || c == sct_pkg::CH_STAR ||
           c == sct_pkg::CH_LT || c == sct_pkg::CH_GT || c == sct_pkg::CH_EQ ||
           c == sct_pkg::CH_BANG || c == sct_pkg::CH_AMP || c == sct_pkg::CH_PIPE;
  endfunction

  function automatic logic makes_pair(logic [7:0] a, logic [7:0] b);
    return (a == sct_pkg::CH_PLUS && b == sct_pkg::CH_PLUS) ||
           (a == sct_pkg::CH_MINUS && b == sct_pkg::CH_MINUS) ||
           (a == sct_pkg::CH_STAR && b == sct_pkg::CH_STAR) ||
           (a == sct_pkg::CH_LT && b == sct_pkg::CH_EQ) ||
           (a == sct_pkg::CH_GT && b == sct_pkg::CH_EQ) ||
           (a == sct_pkg::CH_EQ && b == sct_pkg::CH_EQ) ||
           (a == sct_pkg::CH_BANG && b == sct_pkg::CH_EQ) ||
           (a == sct_pkg::CH_AMP && b == sct_pkg::CH_AMP) ||
           (a == sct_pkg::CH_PIPE && b == sct_pkg::CH_PIPE);
  endfunction

  function automatic take_t put(take_t r, logic [7:0] c, logic s, logic e);
    r.res[r.cnt[0]] = '{ch: c, tok_start: s, tok_end: e};
    r.cnt = r.cnt + 2'd1;
    return r;
  endfunction

  function automatic take_t release_held(take_t r);
    if (r.st.held_valid) begin
      r = put(r, r.st.held_op, 1'b1, 1'b1);
      r.st.held_valid = 1'b0;
    end
    return r;
  endfunction

  function automatic take_t single_token(take_t r, logic [7:0] c);
    if (r.st.held_valid && makes_pair(r.st.held_op, c)) begin
      r = put(r, r.st.held_op, 1'b1, 1'b0);
      r = put(r, c, 1'b0, 1'b1);
      r.st.held_valid = 1'b0;
    end else begin
      r = release_held(r);
      if (can_lead(c)) begin
        r.st.held_op    = c;
        r.st.held_valid = 1'b1;
      end else begin
        r = put(r, c, 1'b1, 1'b1);
      end
    end
    return r;
  endfunction

  function automatic take_t open_token(take_t r, logic [7:0] c, sct_pkg::lex_mode_e m);
    r = release_held(r);
    r = put(r, c, 1'b1, 1'b0);
    r.st.tok_open = 1'b1;
    r.st.mode     = m;
    return r;
  endfunction

  function automatic take_t close_token(take_t r);
    r.st.tok_open = 1'b0;
    r.st.mode     = sct_pkg::MODE_IDLE;
    r.st.esc      = sct_pkg::ESC_NONE;
    return r;
  endfunction

  function automatic take_t take_byte(sct_pkg::lex_state_t st, logic [7:0] c,
                                      logic has_next, logic [7:0] n);
    take_t r;
    r     = '0;
    r.st  = st;
    if (st.mode == sct_pkg::MODE_COMMENT) begin
      if (c == sct_pkg::CH_NL) begin
        r.st.mode = sct_pkg::MODE_IDLE;
      end
    end else if (st.tok_open && st.mode == sct_pkg::MODE_STRING &&
                 st.esc != sct_pkg::ESC_NONE) begin
      r.st.esc = (st.esc == sct_pkg::ESC_BSLASH && has_next && n == sct_pkg::CH_QUOTE) ?
                 sct_pkg::ESC_QUOTE : sct_pkg::ESC_NONE;
      r = put(r, c, 1'b0, !has_next);
      if (!has_next) begin
        r = close_token(r);
      end
    end else if (st.mode != sct_pkg::MODE_STRING && has_next &&
                 c == sct_pkg::CH_SLASH && n == sct_pkg::CH_SLASH) begin
      r.st.tok_open = 1'b0;
      r.st.esc      = sct_pkg::ESC_NONE;
      r.st.mode     = sct_pkg::MODE_COMMENT;
    end else if (!st.tok_open) begin
      if (is_space(c)) begin
        r = r;
      end else if (!has_next) begin
        r = single_token(r, c);
      end else if (c == sct_pkg::CH_QUOTE) begin
        r = open_token(r, c, sct_pkg::MODE_STRING);
      end else if (is_mark(c) || is_sep(n)) begin
        r = single_token(r, c);
      end else begin
        r = open_token(r, c, sct_pkg::MODE_WORD);
      end
    end else if (!has_next) begin
      r = put(r, c, 1'b0, 1'b1);
      r = close_token(r);
    end else if (st.mode == sct_pkg::MODE_STRING) begin
      if (c == sct_pkg::CH_BSLASH) begin
        if (n == sct_pkg::CH_BSLASH) begin
          r.st.esc = sct_pkg::ESC_BSLASH;
        end else if (n == sct_pkg::CH_QUOTE) begin
          r.st.esc = sct_pkg::ESC_QUOTE;
        end
        r = put(r, c, 1'b0, 1'b0);
      end else if (c == sct_pkg::CH_QUOTE) begin
        r = put(r, c, 1'b0, 1'b1);
        r = close_token(r);
      end else begin
        r = put(r, c, 1'b0, 1'b0);
      end
    end else begin
      r = put(r, c, 1'b0, is_sep(n));
      if (is_sep(n)) begin
        r = close_token(r);
      end
    end
    return r;
  endfunction

  sct_pkg::lex_state_t  state_q, state_d;
  take_t                t1, t2;
  sct_pkg::tok_t [4:0]  list;
  logic [2:0]           k;

  always_comb begin
    t1    = '0;
    t1.st = state_q;
    if (state_q.la_valid) begin
      t1 = take_byte(state_q, state_q.la_char, 1'b1, item_i.char_in);
    end
    t2    = '0;
    t2.st = t1.st;
    if (item_i.end_of_input) begin
      t2      = take_byte(t1.st, item_i.char_in, 1'b0, 8'h00);
      t2      = release_held(t2);
      state_d = '0;
    end else begin
      state_d          = t1.st;
      state_d.la_char  = item_i.char_in;
      state_d.la_valid = 1'b1;
    end

    // pack both steps into one run, capped at four
    list = '0;
    k    = 3'd0;
    if (t1.cnt > 2'd0) begin
      list[k] = t1.res[0];
      k       = k + 3'd1;
    end
    if (t1.cnt > 2'd1) begin
      list[k] = t1.res[1];
      k       = k + 3'd1;
    end
    if (t2.cnt > 2'd0) begin
      list[k] = t2.res[0];
      k       = k + 3'd1;
    end
    if (t2.cnt > 2'd1) begin
      list[k] = t2.res[1];
      k       = k + 3'd1;
    end
    bundle_o.cnt = (k > 3'(sct_pkg::MaxRes)) ? 3'(sct_pkg::MaxRes) : k;
    bundle_o.res = list[sct_pkg::MaxRes-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/sct_drain.sv]
`timescale 1ns / 1ps
module sct_drain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_accept_i,
  input  sct_pkg::bundle_t    bundle_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sct_pkg::out_item_t  out_data_o
);

  sct_pkg::bundle_t  bundle_q, bundle_d;
  logic [1:0]        idx_q, idx_d;
  logic              busy_q, busy_d;
  logic              is_last;
  logic              take;
  sct_pkg::tok_t     cur;

  assign cur     = bundle_q.res[idx_q];
  assign is_last = ({1'b0, idx_q} == bundle_q.cnt - 3'd1);
  assign take    = busy_q && !out_stall_i;

  assign out_valid_o            = busy_q;
  assign out_data_o.char_out    = cur.ch;
  assign out_data_o.token_start = cur.tok_start;
  assign out_data_o.token_end   = cur.tok_end;
  assign out_data_o.last_of_run = is_last;

  // free this cycle if empty or the last entry leaves now
  assign free_o = !busy_q || (take && is_last);

  always_comb begin
    bundle_d = bundle_q;
    idx_d    = idx_q;
    busy_d   = busy_q;
    if (take) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (in_accept_i && bundle_i.cnt != 3'd0) begin
      bundle_d = bundle_i;
      idx_d    = 2'd0;
      busy_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bundle_q <= bundle_d;
  end

endmodule

[rtl/core/sct_checker.sv]
`timescale 1ns / 1ps
`include "script_character_tokenizer_macros.svh"
module sct_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sct_pkg::in_item_t   in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sct_pkg::out_item_t  out_data_o
);

  // input held off only while results are pending
  `SCT_ASSERT_NOW(a_stall_needs_pending, in_stall_o, out_valid_o)
  // a run goes on in the very next cycle until its last character
  `SCT_ASSERT_NEXT(a_run_continues, out_valid_o && !out_stall_i && !out_data_o.last_of_run, out_valid_o)
  // a stalled result stays offered
  `SCT_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)
  // a stalled result does not change
  `SCT_ASSERT_NEXT(a_out_data_holds, out_valid_o && out_stall_i, $stable(out_data_o))
  // a stalled input transaction stays offered with the same payload
  `SCT_ASSERT_NEXT(a_in_data_holds, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i))

endmodule

bind script_character_tokenizer sct_checker u_sct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import sct_pkg::*;

  localparam int unsigned RandomBytes = 355;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 8;

  // token predictor and the characters it still expects from the block
  class token_predictor;
    logic [7:0]  la_char;
    bit          la_valid;
    lex_mode_e   mode;
    esc_e        esc;
    logic [7:0]  held_op;
    bit          held_valid;
    bit          tok_open;
    tok_t        run_q[$];
    out_item_t   expected_q[$];
    int unsigned n_errors;
    int unsigned n_chars;
    int unsigned n_tokens;

    function new();
      clear();
      n_errors = 0;
      n_chars  = 0;
      n_tokens = 0;
    endfunction

    function void clear();
      la_char    = '0;
      la_valid   = 1'b0;
      mode       = MODE_IDLE;
      esc        = ESC_NONE;
      held_op    = '0;
      held_valid = 1'b0;
      tok_open   = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
    endfunction

    function bit is_mark(logic [7:0] c);
      return c inside {CH_COMMA, CH_SEMI, CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE,
                       CH_LBRACK, CH_RBRACK, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS,
                       CH_EQ, CH_BANG, CH_GT, CH_LT, CH_TILDE, CH_AMP, CH_CARET,
                       CH_PIPE, CH_PCT, CH_HASH};
    endfunction

    function bit is_sep(logic [7:0] c);
      return is_blank(c) || is_mark(c);
    endfunction

    function bit can_lead(logic [7:0] c);
      return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_LT, CH_GT, CH_EQ, CH_BANG,
                       CH_AMP, CH_PIPE};
    endfunction

    function bit forms_pair(logic [7:0] a, logic [7:0] b);
      return (a == b && (a inside {CH_PLUS, CH_MINUS, CH_STAR, CH_AMP, CH_PIPE})) ||
             (b == CH_EQ && (a inside {CH_LT, CH_GT, CH_EQ, CH_BANG}));
    endfunction

    function void emit(logic [7:0] c, bit s, bit e);
      tok_t t;
      if (run_q.size() < MaxRes) begin
        t.ch        = c;
        t.tok_start = s;
        t.tok_end   = e;
        run_q.insert(run_q.size(), t);
      end
    endfunction

    function void release_held();
      if (held_valid) begin
        emit(held_op, 1'b1, 1'b1);
        held_valid = 1'b0;
      end
    endfunction

    function void single_char(logic [7:0] c);
      if (held_valid && forms_pair(held_op, c)) begin
        emit(held_op, 1'b1, 1'b0);
        emit(c, 1'b0, 1'b1);
        held_valid = 1'b0;
        return;
      end
      release_held();
      if (can_lead(c)) begin
        held_op    = c;
        held_valid = 1'b1;
      end else begin
        emit(c, 1'b1, 1'b1);
      end
    endfunction

    function void open_tok(logic [7:0] c, lex_mode_e m);
      release_held();
      emit(c, 1'b1, 1'b0);
      tok_open = 1'b1;
      mode     = m;
    endfunction

    function void close_tok();
      tok_open = 1'b0;
      mode     = MODE_IDLE;
      esc      = ESC_NONE;
    endfunction

    function void consume(logic [7:0] c, bit has_next, logic [7:0] n);
      if (mode == MODE_COMMENT) begin
        if (c == CH_NL) mode = MODE_IDLE;
        return;
      end
      if (tok_open && mode == MODE_STRING && esc != ESC_NONE) begin
        esc = (esc == ESC_BSLASH && has_next && n == CH_QUOTE) ? ESC_QUOTE : ESC_NONE;
        emit(c, 1'b0, !has_next);
        if (!has_next) close_tok();
        return;
      end
      if (mode != MODE_STRING && has_next && c == CH_SLASH && n == CH_SLASH) begin
        tok_open = 1'b0;
        esc      = ESC_NONE;
        mode     = MODE_COMMENT;
        return;
      end
      if (!tok_open) begin
        if (is_blank(c)) return;
        if (!has_next) begin
          single_char(c);
        end else if (c == CH_QUOTE) begin
          open_tok(c, MODE_STRING);
        end else if (is_mark(c) || is_sep(n)) begin
          single_char(c);
        end else begin
          open_tok(c, MODE_WORD);
        end
        return;
      end
      if (!has_next) begin
        emit(c, 1'b0, 1'b1);
        close_tok();
        return;
      end
      if (mode == MODE_STRING) begin
        if (c == CH_BSLASH) begin
          if (n == CH_BSLASH) esc = ESC_BSLASH;
          else if (n == CH_QUOTE) esc = ESC_QUOTE;
          emit(c, 1'b0, 1'b0);
        end else if (c == CH_QUOTE) begin
          emit(c, 1'b0, 1'b1);
          close_tok();
        end else begin
          emit(c, 1'b0, 1'b0);
        end
        return;
      end
      if (is_sep(n)) begin
        emit(c, 1'b0, 1'b1);
        close_tok();
      end else begin
        emit(c, 1'b0, 1'b0);
      end
    endfunction

    function void note_byte(in_item_t it);
      out_item_t r;
      run_q.delete();
      if (la_valid) consume(la_char, 1'b1, it.char_in);
      if (it.end_of_input) begin
        consume(it.char_in, 1'b0, 8'h00);
        release_held();
        clear();
      end else begin
        la_char  = it.char_in;
        la_valid = 1'b1;
      end
      foreach (run_q[i]) begin
        r.char_out    = run_q[i].ch;
        r.token_start = run_q[i].tok_start;
        r.token_end   = run_q[i].tok_end;
        r.last_of_run = (i == run_q.size() - 1);
        expected_q.insert(expected_q.size(), r);
      end
    endfunction

    function void check_char(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %02h s%0b e%0b l%0b",
                 $time, got.char_out, got.token_start, got.token_end, got.last_of_run);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      n_chars++;
      if (want.token_end) n_tokens++;
      if (got.char_out !== want.char_out) begin
        $display("%0t: char_out expected %02h, got %02h", $time, want.char_out, got.char_out);
        n_errors++;
      end
      if (got.token_start !== want.token_start) begin
        $display("%0t: token_start expected %0b, got %0b", $time, want.token_start,
                 got.token_start);
        n_errors++;
      end
      if (got.token_end !== want.token_end) begin
        $display("%0t: token_end expected %0b, got %0b", $time, want.token_end,
                 got.token_end);
        n_errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b, got %0b", $time, want.last_of_run,
                 got.last_of_run);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;

  token_predictor lexer;
  logic [7:0]     script_q[$];
  bit             calm = 1'b0;       // no gaps and no stalls on either side
  int unsigned    n_scripts = 0;
  int unsigned    n_bytes = 0;
  int unsigned    cycle_cnt = 0;

  script_character_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog, well beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // both handshakes are sampled with pre-edge values, so the order of
  // processes within the step does not matter
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) lexer.note_byte(in_data_i);
      if (out_valid_o && !out_stall_i) lexer.check_char(out_data_o);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // append one byte to the script being built
  function automatic void add_byte(logic [7:0] c);
    script_q.insert(script_q.size(), c);
  endfunction

  // character pools for script generation
  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_NL;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // punctuation that never starts a two-character operator
  function automatic logic [7:0] pick_mark();
    case ($urandom_range(0, 12))
      0:       return CH_COMMA;
      1:       return CH_SEMI;
      2:       return CH_LPAR;
      3:       return CH_RPAR;
      4:       return CH_LBRACE;
      5:       return CH_RBRACE;
      6:       return CH_LBRACK;
      7:       return CH_RBRACK;
      8:       return CH_TILDE;
      9:       return CH_CARET;
      10:      return CH_PCT;
      11:      return CH_HASH;
      default: return CH_SLASH;
    endcase
  endfunction

  // first characters of ++ -- ** <= >= == != && ||
  function automatic logic [7:0] pick_lead();
    case ($urandom_range(0, 8))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_LT;
      4:       return CH_GT;
      5:       return CH_EQ;
      6:       return CH_BANG;
      7:       return CH_AMP;
      default: return CH_PIPE;
    endcase
  endfunction

  function automatic logic [7:0] pair_second(logic [7:0] op);
    return (op inside {CH_PLUS, CH_MINUS, CH_STAR, CH_AMP, CH_PIPE}) ? op : CH_EQ;
  endfunction

  // letters, digits, high bytes, and the odd quote or backslash inside a word
  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 7))
      0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
      3:       return 8'h30 + 8'($urandom_range(0, 9));
      4:       return 8'($urandom_range(128, 255));
      5:       return 8'h5F;
      6:       return CH_BSLASH;
      default: return ($urandom_range(0, 2) == 0) ? CH_QUOTE : 8'h41 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // one script: mostly well-formed token sequences, sometimes raw noise
  function automatic void build_script();
    int unsigned n_tok;
    int unsigned k;
    logic [7:0]  op;
    script_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 5))
          0:       add_byte(pick_blank());
          1:       add_byte(pick_mark());
          2:       add_byte(pick_lead());
          3:       add_byte(($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_BSLASH);
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    n_tok = $urandom_range(1, 7);
    for (k = 0; k < n_tok; k++) begin
      // tokens are sometimes glued together with no whitespace
      if (k != 0 && $urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 2)) add_byte(pick_blank());
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 5)) add_byte(pick_word_char());
        3, 4: begin
          op = pick_lead();
          add_byte(op);
          if ($urandom_range(0, 1) == 0) add_byte(pair_second(op));
        end
        5: add_byte(pick_mark());
        6, 7: begin
          // string body with escaped backslashes and quotes, sometimes unterminated
          add_byte(CH_QUOTE);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 4))
              0: begin
                add_byte(CH_BSLASH);
                add_byte(CH_BSLASH);
              end
              1: begin
                add_byte(CH_BSLASH);
                add_byte(CH_QUOTE);
              end
              2: begin
                add_byte(CH_BSLASH);
                add_byte(CH_BSLASH);
                add_byte(CH_QUOTE);
              end
              3:       add_byte(pick_blank());
              default: add_byte(8'h61 + 8'($urandom_range(0, 25)));
            endcase
          end
          if ($urandom_range(0, 4) != 0) add_byte(CH_QUOTE);
        end
        8: begin
          add_byte(CH_SLASH);
          add_byte(CH_SLASH);
          repeat ($urandom_range(0, 3)) add_byte(pick_word_char());
          if ($urandom_range(0, 4) != 0) add_byte(CH_NL);
        end
        default: begin
          // operator pair split by whitespace or by a comment
          op = pick_lead();
          add_byte(op);
          if ($urandom_range(0, 1) == 0) begin
            add_byte(pick_blank());
          end else begin
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
            add_byte(CH_NL);
          end
          add_byte(pair_second(op));
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) add_byte(pick_blank());
  endfunction

  task automatic load_text(string s);
    int unsigned k;
    script_q.delete();
    for (k = 0; k < s.len(); k++) add_byte(s[k]);
  endtask

  // one input transaction, entered and left at a rising edge
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_bytes++;
  endtask

  // the final byte of a script carries the end flag
  task automatic send_script();
    in_item_t it;
    foreach (script_q[i]) begin
      it.char_in      = script_q[i];
      it.end_of_input = (i == script_q.size() - 1);
      send_item(it);
    end
    n_scripts++;
  endtask

  // hold the sender until every expected character has come out;
  // the count is read at the falling edge, clear of the monitor's update
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (lexer.expected_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // receiver back-pressure, random stall runs of varying length
  initial begin : sink_side
    int unsigned hold;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int unsigned directed_bytes;
    lexer = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lowest and highest byte values in one word
    script_q = '{8'h00, 8'hFF};
    send_script();
    // operator merge across whitespace
    load_text("+ +");
    send_script();
    // operator merge across a comment
    load_text("<//c\n=");
    send_script();
    // escaped backslash then escaped quote, string left open at the end
    load_text("\"\\\\\"");
    send_script();
    // lone quote as the final byte
    load_text("\"");
    send_script();
    // whitespace as the final byte still closes the open string
    load_text("\"a ");
    send_script();
    // pair followed by a plain mark
    load_text("!=;");
    send_script();
    wait_for_drain();
    directed_bytes = n_bytes;

    // random scripts, with a full drain every eighth one
    while (n_bytes - directed_bytes < RandomBytes) begin
      calm = ($urandom_range(0, 7) == 0);
      build_script();
      send_script();
      if (n_scripts % 8 == 0) wait_for_drain();
    end
    calm = 1'b0;
    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d scripts and %0d source bytes", n_scripts, n_bytes);
    $display("checked %0d token characters over %0d tokens", lexer.n_chars, lexer.n_tokens);
    if (lexer.n_errors == 0 && lexer.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
